FILE: rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and payload types of the LZ window token decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    localparam int MAX_WINDOW_BITS   = 16;
    localparam int MAX_MATCH_LEN     = 256;
    localparam int MIN_WINDOW_BITS   = 11;
    localparam int RESET_WINDOW_BITS = 13;

    localparam int CODE_W  = 9;
    localparam int DIST_W  = 16;
    localparam int WBITS_W = 5;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 3;
    localparam int LANES   = 4;

    localparam logic [CODE_W-1:0] LITERAL_LIMIT = CODE_W'(256);
    localparam logic [CODE_W:0]   MATCH_BIAS    = (CODE_W + 1)'(253);
    localparam logic [BYTE_W-1:0] SPACE_BYTE    = 8'h20;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [WBITS_W-1:0] wbits_t;

endpackage

FILE: rtl/lzwd_if.sv
// ----------------------------------------------------------------------------
// lzwd_in_if / lzwd_out_if
// Valid/ready channels for incoming tokens and outgoing byte groups.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
    logic           valid;
    logic           ready;
    lzwd_pkg::code_t code;
    lzwd_pkg::dist_t distance_minus_one;

    modport source (output valid, output code, output distance_minus_one, input ready);
    modport sink   (input valid, input code, input distance_minus_one, output ready);
endinterface

interface lzwd_out_if;
    logic             valid;
    logic             ready;
    lzwd_pkg::byte_t  byte_a;
    lzwd_pkg::byte_t  byte_b;
    lzwd_pkg::byte_t  byte_c;
    lzwd_pkg::byte_t  byte_d;
    lzwd_pkg::count_t byte_count;
    logic             last;

    modport source (output valid, output byte_a, output byte_b, output byte_c,
                    output byte_d, output byte_count, output last, input ready);
    modport sink   (input valid, input byte_a, input byte_b, input byte_c,
                    input byte_d, input byte_count, input last, output ready);
endinterface

FILE: rtl/lzwd_ram.sv
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// A read in the same cycle as a write to the same address returns old data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/lz_window_token_decoder_top.sv
// ----------------------------------------------------------------------------
// lz_window_token_decoder_top
// LZSS sliding-window decoder: literals and matches into byte groups of up to four.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, match bytes through the window RAM read port;
//   output stalls hold the byte pipeline. A new token is taken only once every
//   byte of the previous token has been consumed.
// Reset: a clearing pass writes spaces to all 2**MAX_WINDOW_BITS window
//   entries; no token is taken until it ends, window_bits writes are
//   taken throughout.
// ----------------------------------------------------------------------------
module lz_window_token_decoder_top #(
    parameter int MAX_WINDOW_BITS = lzwd_pkg::MAX_WINDOW_BITS,
    parameter int MAX_MATCH_LEN   = lzwd_pkg::MAX_MATCH_LEN
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             window_bits_we,
    input  lzwd_pkg::wbits_t window_bits,
    lzwd_in_if.sink          tokens,
    lzwd_out_if.source       results
);

    localparam int AW    = MAX_WINDOW_BITS;
    localparam int LEN_W = $clog2(MAX_MATCH_LEN + 1);
    localparam int LN    = lzwd_pkg::LANES;
    localparam int LCW   = $clog2(LN);

    // configuration
    lzwd_pkg::wbits_t window_bits_reg;
    lzwd_pkg::wbits_t eff_bits;
    logic [AW-1:0]    mask_cur;

    // clearing pass
    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    // token sequencer
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    mask_reg, mask_next;
    logic             lit_reg, lit_next;
    lzwd_pkg::byte_t  lit_byte_reg, lit_byte_next;

    // byte in flight
    logic             bv_reg, bv_next;
    logic             bl_reg, bl_next;
    logic             fwd_hit_reg, fwd_hit_next;
    lzwd_pkg::byte_t  fwd_data_reg, fwd_data_next;
    lzwd_pkg::byte_t  cur_byte;

    // group assembly and output register
    lzwd_pkg::byte_t  lane_reg [LN];
    lzwd_pkg::byte_t  lane_next [LN];
    logic [LCW-1:0]   lane_cnt_reg, lane_cnt_next;
    logic             out_valid_reg, out_valid_next;
    lzwd_pkg::byte_t  out_byte_reg [LN];
    lzwd_pkg::byte_t  out_byte_next [LN];
    lzwd_pkg::count_t out_count_reg, out_count_next;
    logic             out_last_reg, out_last_next;

    // RAM port
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    lzwd_pkg::byte_t ram_wdata, ram_rdata;

    logic accept, issue, consume, group_done;

    logic [lzwd_pkg::CODE_W:0] len_raw;
    logic [LEN_W-1:0]          len_tok;
    logic [AW-1:0]             pos_acc;
    lzwd_pkg::dist_t           src_wide;
    logic                      is_literal;

    // ---------------- window size ----------------
    always_comb
    begin
        priority if (window_bits_reg < lzwd_pkg::WBITS_W'(lzwd_pkg::MIN_WINDOW_BITS))
            eff_bits = lzwd_pkg::WBITS_W'(lzwd_pkg::MIN_WINDOW_BITS);
        else if (window_bits_reg > lzwd_pkg::WBITS_W'(MAX_WINDOW_BITS))
            eff_bits = lzwd_pkg::WBITS_W'(MAX_WINDOW_BITS);
        else
            eff_bits = window_bits_reg;
        for (int i = 0; i < AW; i++)
        begin
            mask_cur[i] = (lzwd_pkg::WBITS_W'(i) < eff_bits);
        end
    end

    // ---------------- handshake ----------------
    assign tokens.ready = !clr_busy_reg && (rem_reg == '0) && !bv_reg;
    assign accept       = tokens.valid && tokens.ready;

    assign cur_byte   = lit_reg ? lit_byte_reg : (fwd_hit_reg ? fwd_data_reg : ram_rdata);
    assign group_done = (lane_cnt_reg == LCW'(LN - 1)) || bl_reg;
    assign consume    = bv_reg && !(group_done && out_valid_reg && !results.ready);
    assign issue      = (rem_reg != '0) && (!bv_reg || consume);

    // ---------------- token setup ----------------
    always_comb
    begin
        is_literal = tokens.code < lzwd_pkg::LITERAL_LIMIT;
        len_raw    = {1'b0, tokens.code} - lzwd_pkg::MATCH_BIAS;
        if (is_literal)
            len_tok = LEN_W'(1);
        else if (len_raw > (lzwd_pkg::CODE_W + 1)'(MAX_MATCH_LEN))
            len_tok = LEN_W'(MAX_MATCH_LEN);
        else
            len_tok = len_raw[LEN_W-1:0];
        pos_acc  = wp_reg & mask_cur;
        src_wide = lzwd_pkg::DIST_W'(pos_acc) - tokens.distance_minus_one - 16'd1;
    end

    // ---------------- next state ----------------
    always_comb
    begin
        clr_busy_next  = clr_busy_reg;
        clr_addr_next  = clr_addr_reg;
        rem_next       = rem_reg;
        src_next       = src_reg;
        wp_next        = wp_reg;
        mask_next      = mask_reg;
        lit_next       = lit_reg;
        lit_byte_next  = lit_byte_reg;
        bv_next        = bv_reg;
        bl_next        = bl_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_data_next  = fwd_data_reg;
        lane_next      = lane_reg;
        lane_cnt_next  = lane_cnt_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_byte_next  = out_byte_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;

        ram_we    = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = cur_byte;
        ram_re    = 1'b0;
        ram_raddr = src_reg;

        if (clr_busy_reg)
        begin
            ram_we        = 1'b1;
            ram_waddr     = clr_addr_reg;
            ram_wdata     = lzwd_pkg::SPACE_BYTE;
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == '1)
                clr_busy_next = 1'b0;
        end

        if (accept)
        begin
            rem_next      = len_tok;
            mask_next     = mask_cur;
            wp_next       = pos_acc;
            src_next      = src_wide[AW-1:0] & mask_cur;
            lit_next      = is_literal;
            lit_byte_next = tokens.code[lzwd_pkg::BYTE_W-1:0];
        end

        if (consume)
        begin
            ram_we  = 1'b1;
            wp_next = (wp_reg + AW'(1)) & mask_reg;
            if (group_done)
            begin
                out_valid_next = 1'b1;
                out_count_next = lzwd_pkg::COUNT_W'(lane_cnt_reg) + lzwd_pkg::COUNT_W'(1);
                out_last_next  = bl_reg;
                for (int i = 0; i < LN; i++)
                begin
                    if (LCW'(i) == lane_cnt_reg)
                        out_byte_next[i] = cur_byte;
                    else if (LCW'(i) < lane_cnt_reg)
                        out_byte_next[i] = lane_reg[i];
                    else
                        out_byte_next[i] = '0;
                end
                lane_cnt_next = '0;
            end
            else
            begin
                lane_next[lane_cnt_reg] = cur_byte;
                lane_cnt_next = lane_cnt_reg + LCW'(1);
            end
        end

        if (issue)
        begin
            ram_re   = !lit_reg;
            rem_next = rem_reg - LEN_W'(1);
            bv_next  = 1'b1;
            bl_next  = (rem_reg == LEN_W'(1));
            src_next = (src_reg + AW'(1)) & mask_reg;
            // the byte written this cycle is not yet visible at the RAM output
            fwd_hit_next  = consume && (wp_reg == src_reg);
            fwd_data_next = cur_byte;
        end
        else if (consume)
        begin
            bv_next = 1'b0;
        end
    end

    lzwd_ram #(
        .WIDTH (lzwd_pkg::BYTE_W),
        .DEPTH (2 ** AW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_bits_reg <= lzwd_pkg::WBITS_W'(lzwd_pkg::RESET_WINDOW_BITS);
            clr_busy_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            rem_reg         <= '0;
            wp_reg          <= '0;
            mask_reg        <= '0;
            lit_reg         <= 1'b0;
            bv_reg          <= 1'b0;
            bl_reg          <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            lane_cnt_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (window_bits_we)
                window_bits_reg <= window_bits;
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            rem_reg       <= rem_next;
            wp_reg        <= wp_next;
            mask_reg      <= mask_next;
            lit_reg       <= lit_next;
            bv_reg        <= bv_next;
            bl_reg        <= bl_next;
            fwd_hit_reg   <= fwd_hit_next;
            lane_cnt_reg  <= lane_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        lit_byte_reg  <= lit_byte_next;
        fwd_data_reg  <= fwd_data_next;
        lane_reg      <= lane_next;
        out_byte_reg  <= out_byte_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.byte_a     = out_byte_reg[0];
    assign results.byte_b     = out_byte_reg[1];
    assign results.byte_c     = out_byte_reg[2];
    assign results.byte_d     = out_byte_reg[3];
    assign results.byte_count = out_count_reg;
    assign results.last       = out_last_reg;

    // ---------------- assertions ----------------
    a_idle_no_partial_group: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == '0 && !bv_reg) |-> (lane_cnt_reg == '0))
        else $error("partial byte group left behind at end of token");

    a_final_byte_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && bl_reg) |=> (rem_reg == '0))
        else $error("bytes left to issue after final byte of token");

    a_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !clr_busy_reg) |-> ((ram_waddr & ~mask_reg) == '0))
        else $error("window write outside active window");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_count_reg != '0 &&
                           out_count_reg <= lzwd_pkg::COUNT_W'(LN)))
        else $error("byte group count out of range");

endmodule

FILE: dv/lz_window_token_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// lz_window_token_decoder_top_tb
// Self-checking bench for the LZ window token decoder. Tokens go in through
// the token channel. A shadow copy of the window and the write pointer gives
// the expected byte groups, which are checked against the result channel in
// order. Idle bursts on both sides; the tail runs at full rate.
// ----------------------------------------------------------------------------
module lz_window_token_decoder_top_tb;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct packed {
        lzwd_pkg::byte_t  a;
        lzwd_pkg::byte_t  b;
        lzwd_pkg::byte_t  c;
        lzwd_pkg::byte_t  d;
        lzwd_pkg::count_t count;
        logic             last;
    } byte_group_t;

    logic             clk;
    logic             rst_n;
    logic             window_bits_we;
    lzwd_pkg::wbits_t window_bits;

    lzwd_in_if  token_ch ();
    lzwd_out_if group_ch ();

    lz_window_token_decoder_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_bits_we (window_bits_we),
        .window_bits    (window_bits),
        .tokens         (token_ch),
        .results        (group_ch)
    );

    // shadow decoder state
    lzwd_pkg::byte_t  window_mem [0:(1 << lzwd_pkg::MAX_WINDOW_BITS) - 1];
    logic [15:0]      wr_pos;
    lzwd_pkg::wbits_t wbits_shadow;
    byte_group_t      pending_groups [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    bit  no_idle        = 1'b0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result-side backpressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left     <= stall_left - 1;
            group_ch.ready <= (stall_left == 1);
        end
        else if (!no_idle && $urandom_range(0, 9) == 0)
        begin
            stall_left     <= $urandom_range(1, 19);
            group_ch.ready <= 1'b0;
        end
        else
            group_ch.ready <= 1'b1;
    end

    function automatic logic [15:0] active_window_mask();
        int bits;
        bits = int'(wbits_shadow);
        if (bits < lzwd_pkg::MIN_WINDOW_BITS)
            bits = lzwd_pkg::MIN_WINDOW_BITS;
        if (bits > lzwd_pkg::MAX_WINDOW_BITS)
            bits = lzwd_pkg::MAX_WINDOW_BITS;
        return 16'((1 << bits) - 1);
    endfunction

    // expand one token into its byte groups and update the shadow window
    task automatic decode_token(lzwd_pkg::code_t code, lzwd_pkg::dist_t distance);
        logic [15:0]     mask;
        logic [15:0]     pos;
        logic [15:0]     src;
        int              len;
        lzwd_pkg::byte_t b;
        lzwd_pkg::byte_t lane [lzwd_pkg::LANES];
        byte_group_t     grp;
        mask = active_window_mask();
        pos  = wr_pos & mask;
        src  = '0;
        if (code < lzwd_pkg::LITERAL_LIMIT)
            len = 1;
        else
        begin
            len = int'(code) - int'(lzwd_pkg::MATCH_BIAS);
            if (len > lzwd_pkg::MAX_MATCH_LEN)
                len = lzwd_pkg::MAX_MATCH_LEN;
            src = (pos - distance - 16'd1) & mask;
        end
        for (int k = 0; k < lzwd_pkg::LANES; k++)
            lane[k] = '0;
        for (int i = 0; i < len; i++)
        begin
            if (code < lzwd_pkg::LITERAL_LIMIT)
                b = code[lzwd_pkg::BYTE_W-1:0];
            else
            begin
                b   = window_mem[src];
                src = (src + 16'd1) & mask;
            end
            window_mem[pos] = b;
            pos             = (pos + 16'd1) & mask;
            lane[i % lzwd_pkg::LANES] = b;
            if (i % lzwd_pkg::LANES == lzwd_pkg::LANES - 1 || i == len - 1)
            begin
                grp.a     = lane[0];
                grp.b     = lane[1];
                grp.c     = lane[2];
                grp.d     = lane[3];
                grp.count = lzwd_pkg::count_t'(i % lzwd_pkg::LANES + 1);
                grp.last  = (i == len - 1);
                pending_groups.push_back(grp);
                for (int k = 0; k < lzwd_pkg::LANES; k++)
                    lane[k] = '0;
            end
        end
        wr_pos = pos;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_groups
        byte_group_t want;
        if (rst_n && group_ch.valid && group_ch.ready)
        begin
            if (pending_groups.size() == 0)
            begin
                $display("%0t: unexpected byte group, expected none actual count %0d",
                         $time, group_ch.byte_count);
                mismatch_count++;
            end
            else
            begin
                want = pending_groups.pop_front();
                check_field("byte_a", want.a, group_ch.byte_a);
                check_field("byte_b", want.b, group_ch.byte_b);
                check_field("byte_c", want.c, group_ch.byte_c);
                check_field("byte_d", want.d, group_ch.byte_d);
                check_field("byte_count", want.count, group_ch.byte_count);
                check_field("last", want.last, group_ch.last);
            end
        end
    end

    task automatic send_token(lzwd_pkg::code_t code, lzwd_pkg::dist_t distance);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            token_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        token_ch.valid              <= 1'b1;
        token_ch.code               <= code;
        token_ch.distance_minus_one <= distance;
        @(posedge clk);
        while (!token_ch.ready)
            @(posedge clk);
        decode_token(code, distance);
    endtask

    // stop sending and let every outstanding group come back
    task automatic drain_groups();
        token_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_groups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_window_bits(lzwd_pkg::wbits_t value);
        drain_groups();
        window_bits_we <= 1'b1;
        window_bits    <= value;
        @(posedge clk);
        window_bits_we <= 1'b0;
        wbits_shadow   = value;
    endtask

    // mostly literals and short near matches, some long or far ones
    task automatic send_random(int n);
        lzwd_pkg::code_t code;
        lzwd_pkg::dist_t distance;
        int              kind;
        for (int i = 0; i < n; i++)
        begin
            kind     = $urandom_range(0, 99);
            distance = lzwd_pkg::dist_t'($urandom);
            if (kind < 45)
                code = lzwd_pkg::code_t'($urandom_range(0, 255));
            else if (kind < 90)
            begin
                code = lzwd_pkg::code_t'(int'(lzwd_pkg::MATCH_BIAS) + $urandom_range(3, 18));
                if ($urandom_range(0, 3) != 0)
                    distance = lzwd_pkg::dist_t'($urandom_range(0, 63));
            end
            else
                code = lzwd_pkg::code_t'($urandom_range(256, 511));
            send_token(code, distance);
        end
    endtask

    task automatic test_literals_and_matches();
        // fresh window reads spaces
        send_token(lzwd_pkg::code_t'(256), lzwd_pkg::dist_t'(0));
        send_token(lzwd_pkg::code_t'(8'h00), lzwd_pkg::dist_t'(0));
        send_token(lzwd_pkg::code_t'(8'hFF), lzwd_pkg::dist_t'(16'hFFFF));
        send_token(lzwd_pkg::code_t'(8'h41), lzwd_pkg::dist_t'(16'h5A5A));
        send_token(lzwd_pkg::code_t'(8'h5A), lzwd_pkg::dist_t'(0));
        // overlapping run of one byte, then an overlapping three-byte pattern
        send_token(lzwd_pkg::code_t'(263), lzwd_pkg::dist_t'(0));
        send_token(lzwd_pkg::code_t'(260), lzwd_pkg::dist_t'(2));
        // longest legal match, then saturated lengths with a wrapping distance
        send_token(lzwd_pkg::code_t'(509), lzwd_pkg::dist_t'(16'h0010));
        send_token(lzwd_pkg::code_t'(510), lzwd_pkg::dist_t'(5));
        send_token(lzwd_pkg::code_t'(511), lzwd_pkg::dist_t'(16'hFFFF));
    endtask

    task automatic test_window_bits();
        lzwd_pkg::wbits_t sizes [5] = '{lzwd_pkg::wbits_t'(11), lzwd_pkg::wbits_t'(0),
                                        lzwd_pkg::wbits_t'(16), lzwd_pkg::wbits_t'(31),
                                        lzwd_pkg::wbits_t'(13)};
        foreach (sizes[i])
        begin
            set_window_bits(sizes[i]);
            send_token(lzwd_pkg::code_t'(300), lzwd_pkg::dist_t'(16'hFFFF));
            send_token(lzwd_pkg::code_t'(257), lzwd_pkg::dist_t'(2047));
        end
    endtask

    task automatic test_random_stream();
        set_window_bits(lzwd_pkg::wbits_t'(11));
        send_random(55);
        set_window_bits(lzwd_pkg::wbits_t'(16));
        send_random(55);
        set_window_bits(lzwd_pkg::wbits_t'($urandom_range(0, 31)));
        send_random(55);
        set_window_bits(lzwd_pkg::wbits_t'(14));
        send_random(55);
    endtask

    task automatic test_backlog_pause();
        send_random(10);
        drain_groups();
        send_random(10);
    endtask

    task automatic test_full_rate();
        set_window_bits(lzwd_pkg::wbits_t'($urandom_range(lzwd_pkg::MIN_WINDOW_BITS,
                                                          lzwd_pkg::MAX_WINDOW_BITS)));
        no_idle = 1'b1;
        send_random(40);
    endtask

    initial
    begin
        for (int i = 0; i < (1 << lzwd_pkg::MAX_WINDOW_BITS); i++)
            window_mem[i] = lzwd_pkg::SPACE_BYTE;
        wr_pos       = '0;
        wbits_shadow = lzwd_pkg::wbits_t'(lzwd_pkg::RESET_WINDOW_BITS);

        rst_n                       <= 1'b0;
        window_bits_we              <= 1'b0;
        window_bits                 <= lzwd_pkg::wbits_t'(lzwd_pkg::RESET_WINDOW_BITS);
        token_ch.valid              <= 1'b0;
        token_ch.code               <= '0;
        token_ch.distance_minus_one <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tokens wait on ready while the window clear runs
        test_literals_and_matches();
        test_window_bits();
        test_random_stream();
        test_backlog_pause();
        test_full_rate();

        drain_groups();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_groups.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: lz_window_token_decoder_top.f
rtl/lzwd_pkg.sv
rtl/lzwd_if.sv
rtl/lzwd_ram.sv
rtl/lz_window_token_decoder_top.sv
dv/lz_window_token_decoder_top_tb.sv
